// ===== rtl/core/depq_pkg.sv =====
`default_nettype none
package depq_pkg;
  localparam int PRIO_W = 24;
  localparam int ID_W = 20;
  localparam int STAT_W = 2;
  localparam int ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REM_HI = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REM_LO = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/double_ended_priority_queue.sv =====
`default_nettype none
// Timing: an insert is taken and gives no beat; a dropped insert presents its beat the cycle
// after acceptance; a removal scans every stored entry, then closes the gap by moving each
// later entry one place down, then presents the beat.
// Throughput: one item at a time; a removal holds the input until its beat is taken, set by the
// single memory read port walked by one shared compare unit.
// Reset: rst (synchronous, active high) empties the queue; the store itself is not cleared.
module double_ended_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // action[1:0], priority_req[25:2], client_id[45:26], zeros
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata    // removed_id[19:0], status[21:20], zeros
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = depq_pkg::PRIO_W + depq_pkg::ID_W;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;

  depq_pkg::state_t state, state_next;
  logic [CW-1:0] count;
  logic [31:0]   insert_order;
  logic [CW-1:0] idx;          // scan / shift address
  logic          rd_pend;      // rd_data is valid for address idx-1
  logic          hi_mode;
  logic [AW-1:0] best;
  logic [depq_pkg::PRIO_W-1:0] best_p;
  logic [depq_pkg::ID_W-1:0]   best_id;
  logic [depq_pkg::ID_W-1:0]   out_id;
  logic [depq_pkg::STAT_W-1:0] out_st;

  logic [depq_pkg::ACT_W-1:0]  in_act;
  logic [depq_pkg::PRIO_W-1:0] in_prio;
  logic [depq_pkg::ID_W-1:0]   in_id;
  logic [depq_pkg::PRIO_W-1:0] rd_p;
  logic take;
  logic [CW-1:0] rd_pos;

  assign in_act  = s_tdata[1:0];
  assign in_prio = s_tdata[25:2];
  assign in_id   = s_tdata[45:26];
  assign rd_p    = rd_data[EW-1:depq_pkg::ID_W];
  assign rd_pos  = idx - CW'(1);
  // First element always taken; ties: highest keeps older, lowest moves to newer
  assign take = (rd_pos == '0) || (hi_mode ? (rd_p > best_p) : (rd_p <= best_p));

  logic accept;
  assign accept = s_tvalid && s_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      depq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_act == depq_pkg::ACT_INSERT) begin
            if (count >= CW'(CAPACITY)) state_next = depq_pkg::S_RESULT;
          end else if (in_act == depq_pkg::ACT_REM_HI || in_act == depq_pkg::ACT_REM_LO) begin
            if (count == '0) state_next = depq_pkg::S_RESULT;
            else state_next = depq_pkg::S_SCAN;
          end
        end
      end
      depq_pkg::S_SCAN: begin
        if (rd_pend && idx == count) state_next = depq_pkg::S_SHIFT;
      end
      depq_pkg::S_SHIFT: begin
        if (idx >= count) state_next = depq_pkg::S_RESULT;
      end
      depq_pkg::S_RESULT: begin
        if (m_tready) state_next = depq_pkg::S_IDLE;
      end
      default: state_next = depq_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready = (state == depq_pkg::S_IDLE);
    m_tvalid = (state == depq_pkg::S_RESULT);
    m_tdata  = {2'b00, out_st, out_id};
  end

  // Memory: one read port, one write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AW-1:0] rd_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {in_prio, in_id};
    rd_addr = idx[AW-1:0];
    if (state == depq_pkg::S_IDLE) begin
      wr_en = accept && in_act == depq_pkg::ACT_INSERT && count < CW'(CAPACITY);
    end else if (state == depq_pkg::S_SHIFT) begin
      // rd_data holds entry idx; write it one place down and fetch the next one
      wr_en   = rd_pend && idx < count;
      wr_addr = AW'(idx - CW'(1));
      wr_data = rd_data;
      // First shift cycle fetches entry idx itself
      rd_addr = rd_pend ? AW'(idx + CW'(1)) : idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= depq_pkg::S_IDLE;
      count <= '0;
      insert_order <= '0;
      rd_pend <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        depq_pkg::S_IDLE: begin
          rd_pend <= 1'b0;
          idx <= '0;
          if (accept) begin
            hi_mode <= (in_act == depq_pkg::ACT_REM_HI);
            out_id <= '0;
            if (in_act == depq_pkg::ACT_INSERT) begin
              if (count >= CW'(CAPACITY)) out_st <= depq_pkg::ST_FULL;
              else begin
                count <= count + CW'(1);
                insert_order <= insert_order + 32'd1;
              end
            end else begin
              out_st <= (count == '0) ? depq_pkg::ST_EMPTY : depq_pkg::ST_OK;
            end
          end
        end
        depq_pkg::S_SCAN: begin
          // Issue read for idx, compare the entry read last cycle
          if (rd_pend && take) begin
            best <= AW'(rd_pos);
            best_p <= rd_p;
            best_id <= rd_data[depq_pkg::ID_W-1:0];
          end
          if (rd_pend && idx == count) begin
            // Hold: pick up the final compare's winner for the shift start
            if (take) begin
              idx <= CW'(rd_pos) + CW'(1);
              out_id <= rd_data[depq_pkg::ID_W-1:0];
            end else begin
              idx <= CW'(best) + CW'(1);
              out_id <= best_id;
            end
            rd_pend <= 1'b0;
          end else begin
            idx <= idx + CW'(1);
            rd_pend <= 1'b1;
          end
        end
        depq_pkg::S_SHIFT: begin
          // First cycle issues read of idx; then advance one entry a cycle
          if (idx >= count) begin
            count <= count - CW'(1);
          end else if (rd_pend) begin
            idx <= idx + CW'(1);
          end
          rd_pend <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
